>>> rtl/core/text_chunk_splitter_unit_defines.svh
// Assertion macros shared by the chunk splitter RTL.
`ifndef TEXT_CHUNK_SPLITTER_UNIT_DEFINES_SVH
`define TEXT_CHUNK_SPLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tcs_pkg.sv
package tcs_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int WIN_DEPTH  = MAX_WINDOW + 1;
  // Ring buffer of a power-of-two depth so pointer wrap is free.
  localparam int MEM_DEPTH  = 64;
  localparam int PTR_W      = $clog2(MEM_DEPTH);
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
  localparam int LEN_W      = 6;
  localparam int BYTE_W     = 8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam len_t LEN_RESET = len_t'(MAX_WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_EMIT
  } tcs_state_t;

  // C-locale whitespace or ASCII punctuation.
  function automatic logic is_break(byte_t b);
    return (b == 8'h20) ||
           (b >= 8'h09 && b <= 8'h0D) ||
           (b >= 8'h21 && b <= 8'h2F) ||
           (b >= 8'h3A && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) ||
           (b >= 8'h7B && b <= 8'h7E);
  endfunction

  // Out-of-range lengths saturate to 1..MAX_WINDOW.
  function automatic cnt_t clamp_len(len_t v);
    cnt_t r;
    if (v == '0) begin
      r = cnt_t'(1);
    end else if (v > len_t'(MAX_WINDOW)) begin
      r = cnt_t'(MAX_WINDOW);
    end else begin
      r = cnt_t'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tcs_in_if.sv
interface tcs_in_if;
  logic                       valid;
  logic                       ready;
  logic [tcs_pkg::BYTE_W-1:0] text_byte;
  logic                       final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

>>> rtl/core/tcs_out_if.sv
interface tcs_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcs_pkg::BYTE_W-1:0] out_byte;
  logic                       chunk_end;
  logic                       text_end;
  logic                       run_end;

  modport source (output valid, out_byte, chunk_end, text_end, run_end, input ready);
  modport sink   (input valid, out_byte, chunk_end, text_end, run_end, output ready);
endinterface

>>> rtl/core/text_chunk_splitter_unit.sv
// Greedy word-wrap chunker for a byte stream.
// text_in carries one text byte per item, with final_byte on the last byte of
// a text. chunk_out carries one emitted byte per item, flagged with chunk_end,
// text_end and run_end (last output caused by the current input byte).
// cfg_we/cfg_data write max_len, the largest chunk length; write it only idle.
// Bytes sit in a 64-entry ring buffer with one port, read data registered.
// An input item is accepted in ST_IDLE and then checked in ST_CHECK. Each
// chunk cut then runs a backward break search over offsets from the clamped
// max_len down to 1, stopping at the first break (one buffer read per cycle),
// emits its bytes one per cycle while chunk_out is not stalled, retires the
// cut and checks again. A final remainder is emitted the same way. Each byte
// is emitted at most once. On the way out, a byte passes ST_CHECK (and for a
// cut ST_SEARCH), the registered buffer read and the result register.
// text_in.ready is high only while the block is idle between items.
// The result register lets emission run while the receiver takes the previous
// item; a stall on chunk_out freezes emission with nothing lost.
// Reset empties the buffer, drops any pending result and sets max_len to 32.
`include "text_chunk_splitter_unit_defines.svh"

module text_chunk_splitter_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tcs_pkg::LEN_W-1:0] cfg_data,
  tcs_in_if.sink                    text_in,
  tcs_out_if.source                 chunk_out
);
  import tcs_pkg::*;

  byte_t      mem [MEM_DEPTH];
  byte_t      rdata;
  logic       rd_en;
  ptr_t       rd_addr;
  logic       wr_en;
  ptr_t       wr_addr;

  len_t       max_len;
  cnt_t       m;
  tcs_state_t state, state_next;
  ptr_t       head, head_next;
  cnt_t       fill, fill_next;
  logic       fin, fin_next;
  cnt_t       idx, idx_next;
  cnt_t       probe_idx, probe_idx_next;
  logic       probe_vld, probe_vld_next;
  cnt_t       emit_len, emit_len_next;
  cnt_t       emit_drop, emit_drop_next;
  cnt_t       emit_pos, emit_pos_next;
  logic       pend, pend_next;
  logic       pend_last, pend_last_next;
  logic       run_last, run_last_next;
  logic       text_last, text_last_next;

  logic       out_valid, out_valid_next;
  byte_t      out_byte, out_byte_next;
  logic       out_chunk_end, out_chunk_end_next;
  logic       out_text_end, out_text_end_next;
  logic       out_run_end, out_run_end_next;

  logic       can_load;
  logic       load;
  logic       issue;
  logic       cut_go;
  cnt_t       cut_len;
  cnt_t       cut_drop;
  cnt_t       cut_rest;

  assign m               = clamp_len(max_len);
  assign text_in.ready   = (state == ST_IDLE);
  assign can_load        = !out_valid || chunk_out.ready;
  assign wr_addr         = head + ptr_t'(fill);

  assign chunk_out.valid     = out_valid;
  assign chunk_out.out_byte  = out_byte;
  assign chunk_out.chunk_end = out_chunk_end;
  assign chunk_out.text_end  = out_text_end;
  assign chunk_out.run_end   = out_run_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= text_in.text_byte;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      fin       <= 1'b0;
      probe_vld <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      fill      <= fill_next;
      fin       <= fin_next;
      probe_vld <= probe_vld_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    idx           <= idx_next;
    probe_idx     <= probe_idx_next;
    emit_len      <= emit_len_next;
    emit_drop     <= emit_drop_next;
    emit_pos      <= emit_pos_next;
    pend_last     <= pend_last_next;
    run_last      <= run_last_next;
    text_last     <= text_last_next;
    out_byte      <= out_byte_next;
    out_chunk_end <= out_chunk_end_next;
    out_text_end  <= out_text_end_next;
    out_run_end   <= out_run_end_next;
  end

  // A cut ends either before the break found by the probe or after m bytes.
  always_comb begin
    cut_go   = 1'b0;
    cut_len  = m;
    cut_drop = m;
    if (state == ST_SEARCH && probe_vld) begin
      if (is_break(rdata)) begin
        cut_go   = 1'b1;
        cut_len  = probe_idx;
        cut_drop = cnt_t'(probe_idx + 1'b1);
      end else if (probe_idx == cnt_t'(1)) begin
        cut_go   = 1'b1;
      end
    end
    cut_rest = fill - cut_drop;
  end

  always_comb begin
    state_next         = state;
    head_next          = head;
    fill_next          = fill;
    fin_next           = fin;
    idx_next           = idx;
    probe_idx_next     = probe_idx;
    probe_vld_next     = probe_vld;
    emit_len_next      = emit_len;
    emit_drop_next     = emit_drop;
    emit_pos_next      = emit_pos;
    pend_next          = pend;
    pend_last_next     = pend_last;
    run_last_next      = run_last;
    text_last_next     = text_last;
    rd_en              = 1'b0;
    rd_addr            = head + ptr_t'(idx);
    wr_en              = 1'b0;
    load               = 1'b0;
    issue              = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (text_in.valid) begin
          wr_en      = 1'b1;
          fill_next  = cnt_t'(fill + 1'b1);
          fin_next   = text_in.final_byte;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fill > m) begin
          idx_next       = m;
          probe_vld_next = 1'b0;
          state_next     = ST_SEARCH;
        end else if (fin && fill != '0) begin
          emit_len_next  = fill;
          emit_drop_next = fill;
          emit_pos_next  = '0;
          pend_next      = 1'b0;
          run_last_next  = 1'b1;
          text_last_next = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          fin_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (cut_go) begin
          emit_len_next  = cut_len;
          emit_drop_next = cut_drop;
          emit_pos_next  = '0;
          pend_next      = 1'b0;
          // This cut carries run_end only if no further cut or remainder follows.
          run_last_next  = (cut_rest <= m) && (!fin || cut_rest == '0);
          text_last_next = fin && (cut_rest == '0);
          state_next     = ST_EMIT;
        end else begin
          rd_en          = 1'b1;
          rd_addr        = head + ptr_t'(idx);
          probe_idx_next = idx;
          probe_vld_next = 1'b1;
          idx_next       = cnt_t'(idx - 1'b1);
        end
      end
      ST_EMIT: begin
        load  = pend && can_load;
        issue = (emit_pos != emit_len) && (!pend || can_load);
        if (issue) begin
          rd_en          = 1'b1;
          rd_addr        = head + ptr_t'(emit_pos);
          emit_pos_next  = cnt_t'(emit_pos + 1'b1);
          pend_next      = 1'b1;
          pend_last_next = (cnt_t'(emit_pos + 1'b1) == emit_len);
        end else if (load) begin
          pend_next = 1'b0;
        end
        if (emit_pos == emit_len && (!pend || can_load)) begin
          head_next  = head + ptr_t'(emit_drop);
          fill_next  = fill - emit_drop;
          state_next = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next     = out_valid;
    out_byte_next      = out_byte;
    out_chunk_end_next = out_chunk_end;
    out_text_end_next  = out_text_end;
    out_run_end_next   = out_run_end;
    if (load) begin
      out_valid_next     = 1'b1;
      out_byte_next      = rdata;
      out_chunk_end_next = pend_last;
      out_text_end_next  = pend_last && text_last;
      out_run_end_next   = pend_last && run_last;
    end else if (chunk_out.ready) begin
      out_valid_next = 1'b0;
    end
  end

  `TCS_ASSERT_NEXT(a_fill_grows, clk, rst, text_in.valid && text_in.ready, fill == cnt_t'($past(fill) + 1'b1), "fill did not grow on an accepted item")
  `TCS_ASSERT_HOLDS(a_fill_bound, clk, rst, 1'b1, fill <= cnt_t'(WIN_DEPTH), "buffer fill exceeds window depth")
  `TCS_ASSERT_HOLDS(a_probe_nonzero, clk, rst, state == ST_SEARCH && probe_vld, probe_idx != '0, "break search probed offset zero")
  `TCS_ASSERT_HOLDS(a_emit_len, clk, rst, state == ST_EMIT, emit_len != '0 && emit_len <= m && emit_drop <= fill, "bad chunk length")
  `TCS_ASSERT_HOLDS(a_text_end_flags, clk, rst, out_valid && out_text_end, out_chunk_end && out_run_end, "text end without chunk and run end")

endmodule

>>> bench/text_chunk_splitter_unit_tb.sv
module text_chunk_splitter_unit_tb;
  import tcs_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int RUN_MAX       = 64;

  typedef struct packed {
    byte_t out_byte;
    logic  chunk_end;
    logic  text_end;
    logic  run_end;
  } chunk_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  len_t cfg_data;

  tcs_in_if  text_in ();
  tcs_out_if chunk_out ();

  text_chunk_splitter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .text_in   (text_in),
    .chunk_out (chunk_out)
  );

  // Predictor state: a copy of the window and the length register.
  byte_t win_buf [WIN_DEPTH];
  int    win_fill;
  len_t  wrap_len;

  chunk_result_t chunk_bytes_q[$];

  int error_count;
  int results_seen;
  int sender_idle_pct;
  int sink_idle_pct;
  int sink_hold_len;
  int sink_hold_seq;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_wrap_point(input byte_t b);
    return b inside {[8'h09:8'h0D], [8'h20:8'h2F], [8'h3A:8'h40],
                     [8'h5B:8'h60], [8'h7B:8'h7E]};
  endfunction

  // Appends one accepted byte and queues every chunk byte it releases.
  function automatic void wrap_predict(input byte_t b, input logic fin);
    chunk_result_t run_buf [RUN_MAX];
    int k;
    int m;
    int p;
    int n;
    int d;
    int i;
    k = 0;
    if (wrap_len == '0) begin
      m = 1;
    end else if (wrap_len > len_t'(MAX_WINDOW)) begin
      m = MAX_WINDOW;
    end else begin
      m = int'(wrap_len);
    end
    if (win_fill < WIN_DEPTH) begin
      win_buf[win_fill] = b;
      win_fill++;
    end
    while (win_fill >= m + 1) begin
      p = 0;
      for (i = m; i >= 1 && p == 0; i--) begin
        if (is_wrap_point(win_buf[i])) p = i;
      end
      n = (p != 0) ? p : m;
      for (i = 0; i < n; i++) begin
        run_buf[k] = '{out_byte: win_buf[i], chunk_end: (i == n - 1),
                       text_end: 1'b0, run_end: 1'b0};
        k++;
      end
      // The break byte itself is dropped along with the chunk.
      d = (p != 0) ? p + 1 : m;
      if (d >= win_fill) begin
        win_fill = 0;
      end else begin
        for (i = 0; i < win_fill - d; i++) win_buf[i] = win_buf[i + d];
        win_fill = win_fill - d;
      end
    end
    if (fin) begin
      for (i = 0; i < win_fill; i++) begin
        run_buf[k] = '{out_byte: win_buf[i], chunk_end: (i == win_fill - 1),
                       text_end: 1'b0, run_end: 1'b0};
        k++;
      end
      win_fill = 0;
      if (k > 0) run_buf[k - 1].text_end = 1'b1;
    end
    if (k > 0) run_buf[k - 1].run_end = 1'b1;
    for (i = 0; i < k; i++) chunk_bytes_q.insert(chunk_bytes_q.size(), run_buf[i]);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  task automatic send_byte(input byte_t b, input logic fin);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid      <= 1'b1;
    text_in.text_byte  <= b;
    text_in.final_byte <= fin;
    do @(posedge clk); while (!text_in.ready);
    wrap_predict(b, fin);
  endtask

  // The sender stops until every queued byte has come out, then lets the
  // block return to idle.
  task automatic wait_all_results();
    text_in.valid <= 1'b0;
    while (chunk_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input len_t v);
    wait_all_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    wrap_len = v;
  endtask

  function automatic len_t pick_max_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return len_t'($urandom_range(1, 10));
    if (r < 75) return len_t'($urandom_range(11, 32));
    if (r < 85) return ($urandom_range(0, 1) == 0) ? len_t'(1) : len_t'(MAX_WINDOW);
    if (r < 92) return len_t'(0);
    return len_t'($urandom_range(33, 63));
  endfunction

  // Mostly letters and spaces, so chunks are cut at words most of the time.
  function automatic byte_t wordy_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) return byte_t'(8'h61 + $urandom_range(0, 25));
    if (r < 80) return 8'h20;
    if (r < 90) begin
      case ($urandom_range(0, 4))
        0: return byte_t'($urandom_range(8'h09, 8'h0D));
        1: return byte_t'($urandom_range(8'h21, 8'h2F));
        2: return byte_t'($urandom_range(8'h3A, 8'h40));
        3: return byte_t'($urandom_range(8'h5B, 8'h60));
        default: return byte_t'($urandom_range(8'h7B, 8'h7E));
      endcase
    end
    if (r < 95) return byte_t'(8'h30 + $urandom_range(0, 9));
    return byte_t'($urandom_range(8'h80, 8'hFF));
  endfunction

  task automatic send_random_text(input int len, input bit noisy, input int recut_at);
    byte_t b;
    int i;
    for (i = 0; i < len; i++) begin
      if (recut_at > 0 && i == recut_at) write_max_len(pick_max_len());
      b = noisy ? byte_t'($urandom_range(0, 255)) : wordy_byte();
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic send_string(input string s, input bit with_final);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]), with_final && i == s.len() - 1);
  endtask

  task automatic test_default_length();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_break_cuts();
    write_max_len(len_t'(4));
    // A comma cut first, then a full chunk with no break in it.
    send_string("ab,cdefgh", 1'b1);
  endtask

  task automatic test_empty_remainder();
    write_max_len(len_t'(2));
    // The space cut on the final byte empties the window.
    send_string("ab ", 1'b1);
  endtask

  task automatic test_length_extremes();
    write_max_len(len_t'(0));
    send_string("xyz", 1'b1);
    write_max_len(len_t'(63));
    send_string("abcdef", 1'b0);
  endtask

  task automatic test_length_lowered_mid_text();
    write_max_len(len_t'(1));
    send_byte(8'h2E, 1'b1);
  endtask

  task automatic test_random_phase(input int n_items, input int src_pct, input int snk_pct);
    int sent;
    int len;
    int recut;
    sender_idle_pct = src_pct;
    sink_idle_pct   = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) write_max_len(pick_max_len());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 40);
      recut = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
      send_random_text(len, $urandom_range(0, 9) == 0, recut);
      sent += len;
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    write_max_len(len_t'(8));
    sink_hold_len = 400;
    sink_hold_seq++;
    send_random_text(60, 1'b0, 0);
    wait_all_results();
    send_random_text(30, 1'b0, 0);
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    text_in.valid      <= 1'b0;
    text_in.text_byte  <= '0;
    text_in.final_byte <= 1'b0;
    error_count     = 0;
    results_seen    = 0;
    sink_hold_len   = 0;
    sink_hold_seq   = 0;
    sender_idle_pct = 20;
    sink_idle_pct   = 20;
    win_fill        = 0;
    wrap_len        = LEN_RESET;
    foreach (win_buf[i]) win_buf[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_length();
    test_break_cuts();
    test_empty_remainder();
    test_length_extremes();
    test_length_lowered_mid_text();
    test_random_phase(100, 36, 65);
    test_random_phase(100, 65, 36);
    test_backpressure();
    test_random_phase(100, 0, 0);
    wait_all_results();

    if (error_count == 0) begin
      $display("text_chunk_splitter_unit_tb: PASS");
    end else begin
      $display("text_chunk_splitter_unit_tb: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold;
    int seen_seq;
    hold = 0;
    seen_seq = 0;
    chunk_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_seq != seen_seq) begin
        hold = sink_hold_len;
        seen_seq = sink_hold_seq;
      end
      if (hold > 0) begin
        hold--;
        chunk_out.ready <= 1'b0;
      end else begin
        chunk_out.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    chunk_result_t got;
    chunk_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && chunk_out.valid && chunk_out.ready) begin
        got = '{out_byte: chunk_out.out_byte, chunk_end: chunk_out.chunk_end,
                text_end: chunk_out.text_end, run_end: chunk_out.run_end};
        if (chunk_bytes_q.size() == 0) begin
          report_mismatch($sformatf("result %0d: byte %02h with nothing expected",
                                    results_seen, got.out_byte));
        end else begin
          want = chunk_bytes_q.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("result %0d: out_byte %02h, want %02h",
                                      results_seen, got.out_byte, want.out_byte));
          if (got.chunk_end !== want.chunk_end)
            report_mismatch($sformatf("result %0d: chunk_end %b, want %b",
                                      results_seen, got.chunk_end, want.chunk_end));
          if (got.text_end !== want.text_end)
            report_mismatch($sformatf("result %0d: text_end %b, want %b",
                                      results_seen, got.text_end, want.text_end));
          if (got.run_end !== want.run_end)
            report_mismatch($sformatf("result %0d: run_end %b, want %b",
                                      results_seen, got.run_end, want.run_end));
        end
        results_seen++;
      end
    end
  end

  // Counts cycles with work pending and no item moving on either side.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((text_in.valid && text_in.ready) || (chunk_out.valid && chunk_out.ready) ||
          (!text_in.valid && chunk_bytes_q.size() == 0)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("text_chunk_splitter_unit_tb: FAIL");
    $finish;
  end

endmodule
